>>> rtl/lesf_pkg.sv
// ----------------------------------------------------------------------------
// lesf_pkg: shared constants for the largest empty square finder
// Field widths, register indexes and default grid limits.
// ----------------------------------------------------------------------------
package lesf_pkg;

  // Field widths fixed by the word format
  localparam int DIM_W  = 11;  // grid_width / grid_height registers
  localparam int CHAR_W = 8;   // cell character and obstacle character
  localparam int SIZE_W = 11;  // square side
  localparam int POS_W  = 10;  // reported corner row / column

  // Largest dimension the size registers can express
  localparam int DIM_MAX = (1 << DIM_W) - 1;

  // Default line store limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH    = 2'd0,
    CFG_GRID_HEIGHT   = 2'd1,
    CFG_OBSTACLE_CHAR = 2'd2
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [DIM_W-1:0]  RST_GRID_WIDTH    = 11'd1;
  localparam logic [DIM_W-1:0]  RST_GRID_HEIGHT   = 11'd1;
  localparam logic [CHAR_W-1:0] RST_OBSTACLE_CHAR = 8'd111;

endpackage

>>> rtl/largest_empty_square_finder.sv
// ----------------------------------------------------------------------------
// largest_empty_square_finder: maximal empty square over a streamed grid
//
// Usage:
//   Program grid_width, grid_height and obstacle_char through the cfg_ port
//   while the block is idle. Then stream the grid's cells, one character per
//   input word, in raster order (row 0 left to right, then row 1, ...).
//   A cell whose character equals obstacle_char is blocked; all others are
//   empty. After the last cell of the grid one result word appears on the
//   out_ channel: side of the largest empty square and its top-left corner
//   (first in raster order on ties, size 0 at (0,0) if no empty cell).
//   The next accepted cell starts a new grid.
//
// Throughput: one cell per cycle while the input is not stalled. Each cell
//   costs one read and one write of the line store (one entry per column);
//   the read is issued when the cell is accepted and the write when the cell
//   leaves stage 1, with forwarding when the next cell reads that entry.
// Result: the last cell is registered in stage 1, and the result word is
//   registered in the output register as that cell leaves stage 1.
// Reset: synchronous, active low; clears position, best square and the
//   output valid flag, and reloads the register defaults (1, 1, 'o').
// Stall: while a result waits, cells keep flowing; only a second result
//   that finds the output register still held stalls the input.
// ----------------------------------------------------------------------------
module largest_empty_square_finder
  import lesf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  // cell stream
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CHAR_W-1:0]    in_cell_char,
  // result
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SIZE_W-1:0]    out_best_size,
  output logic [POS_W-1:0]     out_corner_col,
  output logic [POS_W-1:0]     out_corner_row
);

  // Effective limits: a size register cannot exceed DIM_MAX anyway
  localparam int WLIM = (MAX_WIDTH  < DIM_MAX) ? MAX_WIDTH  : DIM_MAX;
  localparam int HLIM = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
  localparam int CW   = (WLIM > 1) ? $clog2(WLIM) : 1;
  localparam int RW   = (HLIM > 1) ? $clog2(HLIM) : 1;
  localparam logic [DIM_W-1:0] WLIM_V = DIM_W'(WLIM);
  localparam logic [DIM_W-1:0] HLIM_V = DIM_W'(HLIM);
  localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0]  grid_width_r;
  logic [DIM_W-1:0]  grid_height_r;
  logic [CHAR_W-1:0] obstacle_char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r    <= RST_GRID_WIDTH;
      grid_height_r   <= RST_GRID_HEIGHT;
      obstacle_char_r <= RST_OBSTACLE_CHAR;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:    grid_width_r    <= cfg_data;
        CFG_GRID_HEIGHT:   grid_height_r   <= cfg_data;
        CFG_OBSTACLE_CHAR: obstacle_char_r <= cfg_data[CHAR_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Clamp the dimensions: zero acts as one, oversize acts as the limit
  logic [DIM_W-1:0] w_eff, h_eff;
  assign w_eff = (grid_width_r == '0) ? DIM_ONE :
                 ((grid_width_r > WLIM_V) ? WLIM_V : grid_width_r);
  assign h_eff = (grid_height_r == '0) ? DIM_ONE :
                 ((grid_height_r > HLIM_V) ? HLIM_V : grid_height_r);

  // --------------------------------------------------------------------------
  // Stage 0: accept a cell, place it in the grid, issue the line read
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;

  logic             in_acc;
  logic [DIM_W-1:0] col_ext, row_ext, c_ext, r_ext;
  logic [CW-1:0]    c_s0;
  logic [RW-1:0]    r_s0;
  logic             last_col_s0, last_row_s0;

  always_comb begin
    col_ext     = DIM_W'(col_r);
    row_ext     = DIM_W'(row_r);
    // a position past the edge counts as the last one
    c_ext       = (col_ext >= w_eff) ? (w_eff - DIM_ONE) : col_ext;
    r_ext       = (row_ext >= h_eff) ? (h_eff - DIM_ONE) : row_ext;
    c_s0        = c_ext[CW-1:0];
    r_s0        = r_ext[RW-1:0];
    last_col_s0 = (c_ext == (w_eff - DIM_ONE));
    last_row_s0 = (r_ext == (h_eff - DIM_ONE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (last_col_s0) begin
        col_r <= '0;
        row_r <= last_row_s0 ? '0 : r_s0 + RW'(1);
      end else begin
        col_r <= c_s0 + CW'(1);
        row_r <= r_s0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 registers
  // --------------------------------------------------------------------------
  logic             s1_valid_r;
  logic             s1_blocked_r;
  logic [CW-1:0]    s1_col_r;
  logic [RW-1:0]    s1_row_r;
  logic             s1_last_col_r;
  logic             s1_last_r;      // last cell of the grid
  logic             fwd_hit_r;
  logic [SIZE_W-1:0] fwd_data_r;

  logic             s1_go;
  logic [SIZE_W-1:0] s1_size;

  // Hold stage 1 only when it carries a result and the output is still full
  assign s1_go    = s1_valid_r && !(s1_last_r && out_valid && out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_blocked_r  <= (in_cell_char == obstacle_char_r);
      s1_col_r      <= c_s0;
      s1_row_r      <= r_s0;
      s1_last_col_r <= last_col_s0;
      s1_last_r     <= last_col_s0 && last_row_s0;
      // the entry being written this cycle is not yet visible to the read
      fwd_hit_r     <= s1_go && (s1_col_r == c_s0);
      fwd_data_r    <= s1_size;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: square sizes of the row above, one entry per column
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] size_line [WLIM];
  logic [SIZE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= size_line[c_s0];
    end
    if (s1_go) begin
      size_line[s1_col_r] <= s1_size;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: size of the square ending here, best tracking
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] left_size_r, diag_size_r;
  logic [SIZE_W-1:0] best_size_r;
  logic [POS_W-1:0]  best_col_r, best_row_r;

  logic [SIZE_W-1:0] up, left, diag, min_ul, min_all;
  logic              first_row, first_col, better;
  logic [SIZE_W-1:0] corner_col_w, corner_row_w;
  logic [SIZE_W-1:0] best_size_nxt;
  logic [POS_W-1:0]  best_col_nxt, best_row_nxt;

  always_comb begin
    first_row = (s1_row_r == '0);
    first_col = (s1_col_r == '0);
    up        = first_row ? '0 : (fwd_hit_r ? fwd_data_r : rd_data_r);
    left      = first_col ? '0 : left_size_r;
    diag      = (first_row || first_col) ? '0 : diag_size_r;
    min_ul    = (up < left) ? up : left;
    min_all   = (min_ul < diag) ? min_ul : diag;
    s1_size   = s1_blocked_r ? '0 : (min_all + SIZE_W'(1));

    // only a strictly larger square replaces the kept one
    better       = (s1_size > best_size_r);
    corner_col_w = SIZE_W'(s1_col_r) + SIZE_W'(1) - s1_size;
    corner_row_w = SIZE_W'(s1_row_r) + SIZE_W'(1) - s1_size;
    best_size_nxt = better ? s1_size            : best_size_r;
    best_col_nxt  = better ? corner_col_w[POS_W-1:0] : best_col_r;
    best_row_nxt  = better ? corner_row_w[POS_W-1:0] : best_row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_size_r <= '0;
      diag_size_r <= '0;
      best_size_r <= '0;
      best_col_r  <= '0;
      best_row_r  <= '0;
    end else if (s1_go) begin
      if (s1_last_r) begin
        // end of grid: start over
        left_size_r <= '0;
        diag_size_r <= '0;
        best_size_r <= '0;
        best_col_r  <= '0;
        best_row_r  <= '0;
      end else begin
        left_size_r <= s1_last_col_r ? '0 : s1_size;
        diag_size_r <= s1_last_col_r ? '0 : up;
        best_size_r <= best_size_nxt;
        best_col_r  <= best_col_nxt;
        best_row_r  <= best_row_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic              out_valid_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [POS_W-1:0]  out_col_r, out_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_size_r <= best_size_nxt;
      out_col_r  <= best_col_nxt;
      out_row_r  <= best_row_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_size  = out_size_r;
  assign out_corner_col = out_col_r;
  assign out_corner_row = out_row_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_from_last_cell: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_last_r))
    else $error("result word without a finished grid");

  a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted cell lost before stage 1");

  a_size_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |-> (s1_size <= SIZE_W'(s1_col_r) + SIZE_W'(1)))
    else $error("square larger than its column allows");

endmodule
